/* rtl/lbsm_pkg.sv */
// Shared types and codes for the LRU buffer slot manager.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lbsm_pkg;

    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_FLUSH   = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_BRICK   = 3'd1;
    localparam logic [2:0] ST_ABSENT     = 3'd2;
    localparam logic [2:0] ST_ALL_PINNED = 3'd3;
    localparam logic [2:0] ST_PIN_FULL   = 3'd4;
    localparam logic [2:0] ST_FREE_FULL  = 3'd5;

    localparam logic [1:0] REG_BRICK_BYTES  = 2'd0;
    localparam logic [1:0] REG_BUFFER_BYTES = 2'd1;
    localparam logic [1:0] REG_REUSE_FREED  = 2'd2;
    localparam logic [1:0] REG_EXISTING     = 2'd3;

    localparam int          MAX_RESULTS = 8;
    localparam logic [15:0] BUF_LIMIT   = 16'hFFFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIV,
        OP_SET_STATUS,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_TGT_HIT,
        OP_TGT_VICTIM,
        OP_STAMP_INC,
        OP_MM_INIT,
        OP_MM_STEP,
        OP_RENORM,
        OP_STAMP_SET,
        OP_REFILL,
        OP_ACCESS_FIN,
        OP_PIN_INIT,
        OP_PIN_STEP,
        OP_PIN_ADD,
        OP_PIN_REL,
        OP_UNPIN,
        OP_PUSH,
        OP_POP_RD,
        OP_POP_FIN,
        OP_ADV,
        OP_EMIT,
        OP_FL_INIT,
        OP_FL_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       no_brick;
        logic       div_done;
        logic       rem_zero;
        logic       reuse;
        logic       free_avail;
        logic       need_buf;
        logic       alloc_limit;
        logic       scan_last;
        logic       hit;
        logic       victim;
        logic       stamp_wrap;
        logic       pin_last;
        logic       any_dirty;
        logic       out_free;
        logic       fl_done;
    } dp_stat_t;

endpackage

/* rtl/lbsm_div.sv */
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 40-bit divisor.
// Standalone; used by the slot manager datapath.
`timescale 1ns / 1ps

module lbsm_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quot,
    output logic [39:0] rem
);
    logic [63:0] q_reg, q_next;
    logic [39:0] r_reg, r_next;
    logic [39:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [40:0] shifted;
    logic        ge;

    always_comb
    begin
        shifted = {r_reg, q_reg[63]};
        ge      = shifted >= {1'b0, d_reg};
        r_next  = ge ? 40'(shifted - {1'b0, d_reg}) : shifted[39:0];
        q_next  = {q_reg[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            // zero size acts as one
            d_reg <= (divisor == '0) ? 40'd1 : divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

/* rtl/lbsm_dp.sv */
// Datapath of the slot manager: config, slot table, pin set, free stack,
// divider and the result register. Depends on lbsm_pkg and lbsm_div.
`timescale 1ns / 1ps

module lbsm_dp
#(
    parameter int SLOTS       = 8,
    parameter int PIN_ENTRIES = 64,
    parameter int FREE_DEPTH  = 64,
    parameter int STAMP_BITS  = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lbsm_pkg::dp_cmd_t cmd,
    output lbsm_pkg::dp_stat_t stat,
    input  logic [2:0]        kind,
    input  logic [63:0]       address,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [39:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [63:0]       result_address,
    output logic [5:0]        slot,
    output logic [39:0]       offset,
    output logic              writeback_valid,
    output logic [15:0]       writeback_buffer,
    output logic              load_valid,
    output logic [15:0]       load_buffer,
    output logic              created_new,
    output logic              last
);
    import lbsm_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int PIW = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
    localparam int FIW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FCW = $clog2(FREE_DEPTH + 1);

    // config
    logic [31:0] brick_reg;
    logic [39:0] bufsz_reg;
    logic        reuse_reg;

    // request
    logic [2:0]  kind_reg;
    logic [63:0] addr_reg;

    // slot table
    logic [15:0]           slot_buf [SLOTS];
    logic [SLOTS-1:0]      slot_val_reg;
    logic [SLOTS-1:0]      slot_dirty_reg;
    logic [STAMP_BITS-1:0] slot_stamp_reg [SLOTS];
    logic [15:0]           slot_pins_reg [SLOTS];

    logic [63:0]           next_addr_reg;
    logic [15:0]           bc_reg;
    logic [STAMP_BITS-1:0] counter_reg;
    logic [2:0]            k_reg;

    // scans
    logic [SW-1:0]         sidx_reg, tgt_reg, hit_idx_reg, vic_idx_reg;
    logic                  hit_f_reg, vic_f_reg;
    logic [STAMP_BITS-1:0] vic_stamp_reg, mn_reg, mx_reg;
    logic [2:0]            fk_reg;

    // pin set
    logic [PIN_ENTRIES-1:0] pin_used_reg;
    logic [63:0]            pin_mem [PIN_ENTRIES];
    logic [63:0]            pin_rd_reg;
    logic [PIW-1:0]         pidx_reg, pd_idx_reg, pm_idx_reg, pf_idx_reg;
    logic                   pd_v_reg, pm_f_reg, pf_f_reg;

    // free stack
    logic [63:0]    free_mem [FREE_DEPTH];
    logic [63:0]    free_rd_reg;
    logic [FCW-1:0] fc_reg;

    // result under construction
    logic [2:0]    r_status_reg;
    logic [63:0]   r_raddr_reg;
    logic [SW-1:0] r_slot_reg;
    logic [39:0]   r_off_reg;
    logic          r_wb_reg, r_ld_reg, r_new_reg;
    logic [15:0]   r_wbbuf_reg, r_ldbuf_reg;

    // output register
    logic          o_valid_reg;
    logic [2:0]    o_status_reg;
    logic [63:0]   o_raddr_reg;
    logic [SW-1:0] o_slot_reg;
    logic [39:0]   o_off_reg;
    logic          o_wb_reg, o_ld_reg, o_new_reg, o_last_reg;
    logic [15:0]   o_wbbuf_reg, o_ldbuf_reg;

    logic [63:0] quot;
    logic [39:0] rem;
    logic        div_done;
    logic        div_start;

    logic [SW-1:0]         sel;
    logic [15:0]           sb;
    logic                  sv, sd;
    logic [STAMP_BITS-1:0] ss;
    logic [15:0]           sp;
    logic                  key_ok, hitc, vicc;
    logic                  out_free, sidx_last;
    logic                  fl_emit, fl_last, more;
    logic [SLOTS-1:0]      vd;
    logic [STAMP_BITS-1:0] cnt_inc;
    logic                  pmatch;
    logic [15:0]           new_buf;

    assign div_start = (cmd.op == OP_DIV);

    lbsm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((kind_reg == KIND_ALLOC) ? next_addr_reg : addr_reg),
        .divisor  (bufsz_reg),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb
    begin
        sel = (cmd.op == OP_SCAN_STEP || cmd.op == OP_MM_STEP || cmd.op == OP_FL_STEP)
              ? sidx_reg : tgt_reg;
        sb  = slot_buf[sel];
        sv  = slot_val_reg[sel];
        sd  = slot_dirty_reg[sel];
        ss  = slot_stamp_reg[sel];
        sp  = slot_pins_reg[sel];
        key_ok   = (quot[63:16] == '0);
        hitc     = sv && key_ok && (sb == quot[15:0]);
        vicc     = (sp == '0) && (!vic_f_reg || vic_stamp_reg > ss);
        out_free = !o_valid_reg || !out_stall;
        sidx_last = (sidx_reg == SW'(SLOTS - 1));
        vd       = slot_val_reg & slot_dirty_reg;
        more     = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (SW'(j) > sidx_reg && vd[j])
                more = 1'b1;
        end
        fl_emit  = (cmd.op == OP_FL_STEP) && sv && sd && out_free;
        fl_last  = (fk_reg == 3'(MAX_RESULTS - 1)) || !more;
        cnt_inc  = counter_reg + 1'b1;
        pmatch   = pin_used_reg[pd_idx_reg] && (pin_rd_reg == addr_reg);
        new_buf  = (kind_reg == KIND_ALLOC) ? bc_reg : quot[15:0];
    end

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.no_brick    = (addr_reg == '1);
        stat.div_done    = div_done;
        stat.rem_zero    = (rem == '0);
        stat.reuse       = reuse_reg;
        stat.free_avail  = (fc_reg != '0);
        stat.need_buf    = (quot >= {48'd0, bc_reg});
        stat.alloc_limit = (k_reg == 3'(MAX_RESULTS - 1)) || (bc_reg >= BUF_LIMIT);
        stat.scan_last   = sidx_last;
        stat.hit         = hit_f_reg;
        stat.victim      = vic_f_reg;
        stat.stamp_wrap  = (cnt_inc == '1);
        stat.pin_last    = pd_v_reg && (pd_idx_reg == PIW'(PIN_ENTRIES - 1));
        stat.any_dirty   = |vd;
        stat.out_free    = out_free;
        stat.fl_done     = fl_emit && fl_last;
    end

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brick_reg      <= 32'd65536;
            bufsz_reg      <= 40'd67108864;
            reuse_reg      <= 1'b0;
            bc_reg         <= '0;
            next_addr_reg  <= '0;
            counter_reg    <= '0;
            slot_val_reg   <= '0;
            slot_dirty_reg <= '0;
            pin_used_reg   <= '0;
            fc_reg         <= '0;
            o_valid_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_stamp_reg[i] <= '0;
                slot_pins_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BRICK_BYTES:  brick_reg <= cfg_data[31:0];
                    REG_BUFFER_BYTES: bufsz_reg <= cfg_data;
                    REG_REUSE_FREED:  reuse_reg <= cfg_data[0];
                    REG_EXISTING:     bc_reg    <= cfg_data[15:0];
                    default:          ;
                endcase
            end

            if (o_valid_reg && !out_stall)
                o_valid_reg <= 1'b0;
            if (cmd.op == OP_EMIT || fl_emit)
                o_valid_reg <= 1'b1;

            case (cmd.op)
                OP_STAMP_INC:
                    counter_reg <= cnt_inc;
                OP_RENORM:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        slot_stamp_reg[i] <= slot_stamp_reg[i] - mn_reg;
                    counter_reg <= mx_reg - mn_reg + 1'b1;
                end
                OP_STAMP_SET:
                    slot_stamp_reg[tgt_reg] <= counter_reg;
                OP_REFILL:
                begin
                    slot_val_reg[tgt_reg]   <= 1'b1;
                    slot_dirty_reg[tgt_reg] <= 1'b0;
                    if (kind_reg == KIND_ALLOC)
                        bc_reg <= bc_reg + 16'd1;
                end
                OP_ACCESS_FIN:
                    if (kind_reg == KIND_WRITE)
                        slot_dirty_reg[tgt_reg] <= 1'b1;
                OP_PIN_ADD:
                    if (!pm_f_reg && pf_f_reg)
                    begin
                        pin_used_reg[pf_idx_reg] <= 1'b1;
                        if (sp != 16'hFFFF)
                            slot_pins_reg[tgt_reg] <= sp + 16'd1;
                    end
                OP_PIN_REL:
                    if (pm_f_reg)
                        pin_used_reg[pm_idx_reg] <= 1'b0;
                OP_UNPIN:
                    if (pm_f_reg && hit_f_reg && sp != '0)
                        slot_pins_reg[tgt_reg] <= sp - 16'd1;
                OP_PUSH:
                    if (addr_reg != '1 && fc_reg < FCW'(FREE_DEPTH))
                        fc_reg <= fc_reg + 1'b1;
                OP_POP_RD:
                    fc_reg <= fc_reg - 1'b1;
                OP_ADV:
                    next_addr_reg <= next_addr_reg + {32'd0, brick_reg};
                OP_FL_STEP:
                    if (fl_emit)
                        slot_dirty_reg[sidx_reg] <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_REFILL)
            slot_buf[tgt_reg] <= new_buf;

        if (cmd.op == OP_EMIT)
        begin
            o_status_reg <= r_status_reg;
            o_raddr_reg  <= r_raddr_reg;
            o_slot_reg   <= r_slot_reg;
            o_off_reg    <= r_off_reg;
            o_wb_reg     <= r_wb_reg;
            o_wbbuf_reg  <= r_wbbuf_reg;
            o_ld_reg     <= r_ld_reg;
            o_ldbuf_reg  <= r_ldbuf_reg;
            o_new_reg    <= r_new_reg;
            o_last_reg   <= cmd.last;
        end
        else if (fl_emit)
        begin
            o_status_reg <= ST_OK;
            o_raddr_reg  <= '0;
            o_slot_reg   <= sidx_reg;
            o_off_reg    <= '0;
            o_wb_reg     <= 1'b1;
            o_wbbuf_reg  <= sb;
            o_ld_reg     <= 1'b0;
            o_ldbuf_reg  <= '0;
            o_new_reg    <= 1'b0;
            o_last_reg   <= fl_last;
        end

        if (cmd.op == OP_ACCEPT || cmd.op == OP_EMIT)
        begin
            r_status_reg <= ST_OK;
            r_raddr_reg  <= '0;
            r_slot_reg   <= '0;
            r_off_reg    <= '0;
            r_wb_reg     <= 1'b0;
            r_wbbuf_reg  <= '0;
            r_ld_reg     <= 1'b0;
            r_ldbuf_reg  <= '0;
            r_new_reg    <= 1'b0;
        end

        case (cmd.op)
            OP_ACCEPT:
            begin
                kind_reg <= kind;
                addr_reg <= address;
                k_reg    <= '0;
            end
            OP_SET_STATUS:
                r_status_reg <= cmd.code;
            OP_SCAN_INIT:
            begin
                sidx_reg  <= '0;
                hit_f_reg <= 1'b0;
                vic_f_reg <= 1'b0;
            end
            OP_SCAN_STEP:
            begin
                if (hitc && !hit_f_reg)
                begin
                    hit_f_reg   <= 1'b1;
                    hit_idx_reg <= sidx_reg;
                end
                if (vicc)
                begin
                    vic_f_reg     <= 1'b1;
                    vic_idx_reg   <= sidx_reg;
                    vic_stamp_reg <= ss;
                end
                if (!sidx_last)
                    sidx_reg <= sidx_reg + 1'b1;
            end
            OP_TGT_HIT:
                tgt_reg <= hit_idx_reg;
            OP_TGT_VICTIM:
                tgt_reg <= vic_idx_reg;
            OP_MM_INIT:
            begin
                sidx_reg <= '0;
                mn_reg   <= '1;
                mx_reg   <= '0;
            end
            OP_MM_STEP:
            begin
                if (ss < mn_reg)
                    mn_reg <= ss;
                if (ss > mx_reg)
                    mx_reg <= ss;
                if (!sidx_last)
                    sidx_reg <= sidx_reg + 1'b1;
            end
            OP_REFILL:
            begin
                if (sv && sd)
                begin
                    r_wb_reg    <= 1'b1;
                    r_wbbuf_reg <= sb;
                end
                if (kind_reg == KIND_ALLOC)
                begin
                    r_new_reg  <= 1'b1;
                    r_slot_reg <= tgt_reg;
                    k_reg      <= k_reg + 3'd1;
                end
                else
                begin
                    r_ld_reg    <= 1'b1;
                    r_ldbuf_reg <= quot[15:0];
                end
            end
            OP_ACCESS_FIN:
            begin
                r_slot_reg <= tgt_reg;
                r_off_reg  <= rem;
            end
            OP_PIN_INIT:
            begin
                pidx_reg <= '0;
                pd_v_reg <= 1'b0;
                pm_f_reg <= 1'b0;
                pf_f_reg <= 1'b0;
            end
            OP_PIN_STEP:
            begin
                pin_rd_reg <= pin_mem[pidx_reg];
                pd_idx_reg <= pidx_reg;
                pd_v_reg   <= 1'b1;
                if (pidx_reg != PIW'(PIN_ENTRIES - 1))
                    pidx_reg <= pidx_reg + 1'b1;
                if (pd_v_reg)
                begin
                    if (pmatch && !pm_f_reg)
                    begin
                        pm_f_reg   <= 1'b1;
                        pm_idx_reg <= pd_idx_reg;
                    end
                    if (!pin_used_reg[pd_idx_reg] && !pf_f_reg)
                    begin
                        pf_f_reg   <= 1'b1;
                        pf_idx_reg <= pd_idx_reg;
                    end
                end
            end
            OP_PIN_ADD:
                if (!pm_f_reg)
                begin
                    if (pf_f_reg)
                        pin_mem[pf_idx_reg] <= addr_reg;
                    else
                        r_status_reg <= ST_PIN_FULL;
                end
            OP_PUSH:
                if (fc_reg < FCW'(FREE_DEPTH))
                    free_mem[fc_reg[FIW-1:0]] <= addr_reg;
                else
                    r_status_reg <= ST_FREE_FULL;
            OP_POP_RD:
                free_rd_reg <= free_mem[FIW'(fc_reg - 1'b1)];
            OP_POP_FIN:
                r_raddr_reg <= free_rd_reg;
            OP_ADV:
                r_raddr_reg <= next_addr_reg;
            OP_FL_INIT:
            begin
                sidx_reg <= '0;
                fk_reg   <= '0;
            end
            OP_FL_STEP:
            begin
                if (fl_emit)
                    fk_reg <= fk_reg + 3'd1;
                if ((fl_emit || !(sv && sd)) && !sidx_last)
                    sidx_reg <= sidx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid        = o_valid_reg;
    assign status           = o_status_reg;
    assign result_address   = o_raddr_reg;
    assign slot             = 6'(o_slot_reg);
    assign offset           = o_off_reg;
    assign writeback_valid  = o_wb_reg;
    assign writeback_buffer = o_wbbuf_reg;
    assign load_valid       = o_ld_reg;
    assign load_buffer      = o_ldbuf_reg;
    assign created_new      = o_new_reg;
    assign last             = o_last_reg;

endmodule

/* rtl/lbsm_ctrl.sv */
// Controller of the slot manager: sequences one request through the datapath.
// Depends on lbsm_pkg.
`timescale 1ns / 1ps

module lbsm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  lbsm_pkg::dp_stat_t stat,
    output logic               in_stall,
    output lbsm_pkg::dp_cmd_t  cmd
);
    import lbsm_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_DISPATCH  = 23'h000002,
        S_DIV_WAIT  = 23'h000004,
        S_POP_FIN   = 23'h000008,
        S_ALLOC_CHK = 23'h000010,
        S_SCAN_INIT = 23'h000020,
        S_SCAN      = 23'h000040,
        S_SCAN_DONE = 23'h000080,
        S_REFILL    = 23'h000100,
        S_STAMP_INC = 23'h000200,
        S_MM_INIT   = 23'h000400,
        S_MM        = 23'h000800,
        S_RENORM    = 23'h001000,
        S_STAMP_SET = 23'h002000,
        S_EMIT_MID  = 23'h004000,
        S_ACCESS    = 23'h008000,
        S_PIN_INIT  = 23'h010000,
        S_PIN       = 23'h020000,
        S_PIN_DONE  = 23'h040000,
        S_REL_DIV   = 23'h080000,
        S_REL_UNPIN = 23'h100000,
        S_EMIT_LAST = 23'h200000,
        S_FLUSH     = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic   is_alloc, is_rel, is_rw;

    assign is_alloc = (stat.kind == KIND_ALLOC);
    assign is_rel   = (stat.kind == KIND_RELEASE);
    assign is_rw    = (stat.kind == KIND_READ) || (stat.kind == KIND_WRITE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.code   = ST_OK;
        cmd.last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
                if (stat.kind == KIND_FLUSH)
                begin
                    if (stat.any_dirty)
                    begin
                        cmd.op     = OP_FL_INIT;
                        state_next = S_FLUSH;
                    end
                    else
                        state_next = S_EMIT_LAST;
                end
                else if ((is_rel || is_rw) && stat.no_brick)
                begin
                    cmd.op     = OP_SET_STATUS;
                    cmd.code   = ST_NO_BRICK;
                    state_next = S_EMIT_LAST;
                end
                else if (is_rel)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_PIN_INIT;
                end
                else if (is_alloc || is_rw)
                begin
                    cmd.op     = OP_DIV;
                    state_next = S_DIV_WAIT;
                end
                else
                    state_next = S_IDLE;
            S_DIV_WAIT:
                if (stat.div_done)
                begin
                    if (is_alloc)
                    begin
                        if (stat.reuse && !stat.rem_zero)
                        begin
                            cmd.op     = OP_ADV;
                            state_next = S_EMIT_LAST;
                        end
                        else if (stat.reuse && stat.free_avail)
                        begin
                            cmd.op     = OP_POP_RD;
                            state_next = S_POP_FIN;
                        end
                        else
                            state_next = S_ALLOC_CHK;
                    end
                    else if (is_rw && stat.need_buf)
                    begin
                        cmd.op     = OP_SET_STATUS;
                        cmd.code   = ST_ABSENT;
                        state_next = S_EMIT_LAST;
                    end
                    else
                        state_next = S_SCAN_INIT;
                end
            S_POP_FIN:
            begin
                cmd.op     = OP_POP_FIN;
                state_next = S_EMIT_LAST;
            end
            S_ALLOC_CHK:
                if (!stat.need_buf)
                begin
                    cmd.op     = OP_ADV;
                    state_next = S_EMIT_LAST;
                end
                else if (stat.alloc_limit)
                begin
                    cmd.op     = OP_SET_STATUS;
                    cmd.code   = ST_ABSENT;
                    state_next = S_EMIT_LAST;
                end
                else
                    state_next = S_SCAN_INIT;
            S_SCAN_INIT:
            begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                    state_next = S_SCAN_DONE;
            end
            S_SCAN_DONE:
                if (is_rel)
                begin
                    cmd.op     = OP_TGT_HIT;
                    state_next = S_REL_UNPIN;
                end
                else if (is_rw && stat.hit)
                begin
                    cmd.op     = OP_TGT_HIT;
                    state_next = S_STAMP_INC;
                end
                else if (stat.victim)
                begin
                    cmd.op     = OP_TGT_VICTIM;
                    state_next = S_REFILL;
                end
                else
                begin
                    cmd.op     = OP_SET_STATUS;
                    cmd.code   = ST_ALL_PINNED;
                    state_next = S_EMIT_LAST;
                end
            S_REFILL:
            begin
                cmd.op     = OP_REFILL;
                state_next = S_STAMP_INC;
            end
            S_STAMP_INC:
            begin
                cmd.op     = OP_STAMP_INC;
                state_next = stat.stamp_wrap ? S_MM_INIT : S_STAMP_SET;
            end
            S_MM_INIT:
            begin
                cmd.op     = OP_MM_INIT;
                state_next = S_MM;
            end
            S_MM:
            begin
                cmd.op = OP_MM_STEP;
                if (stat.scan_last)
                    state_next = S_RENORM;
            end
            S_RENORM:
            begin
                cmd.op     = OP_RENORM;
                state_next = S_STAMP_SET;
            end
            S_STAMP_SET:
            begin
                cmd.op     = OP_STAMP_SET;
                state_next = is_alloc ? S_EMIT_MID : S_ACCESS;
            end
            S_EMIT_MID:
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_ALLOC_CHK;
                end
            S_ACCESS:
            begin
                cmd.op     = OP_ACCESS_FIN;
                state_next = S_PIN_INIT;
            end
            S_PIN_INIT:
            begin
                cmd.op     = OP_PIN_INIT;
                state_next = S_PIN;
            end
            S_PIN:
            begin
                cmd.op = OP_PIN_STEP;
                if (stat.pin_last)
                    state_next = S_PIN_DONE;
            end
            S_PIN_DONE:
                if (is_rel)
                begin
                    cmd.op     = OP_PIN_REL;
                    state_next = S_REL_DIV;
                end
                else
                begin
                    cmd.op     = OP_PIN_ADD;
                    state_next = S_EMIT_LAST;
                end
            S_REL_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_DIV_WAIT;
            end
            S_REL_UNPIN:
            begin
                cmd.op     = OP_UNPIN;
                state_next = S_EMIT_LAST;
            end
            S_EMIT_LAST:
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            S_FLUSH:
            begin
                cmd.op = OP_FL_STEP;
                if (stat.fl_done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/lru_buffer_slot_manager_unit.sv */
// LRU buffer slot manager: one request in, one or more results out.
// A request is accepted when in_valid is high and in_stall is low; a result
// transfers when out_valid is high and out_stall is low, and last marks the
// final result of a request. Allocate gives one result per new buffer and a
// final one with the address; release, read and write give one result;
// flush gives one result per dirty slot (at most eight) or one empty result.
// Requests are handled one at a time. Read and write use the divider for
// buffer and offset, a one-slot-per-cycle scan for hit and victim, and a
// one-entry-per-cycle scan of the pin memory. Release uses the same three
// steps; allocate uses the divider once and a slot scan per new buffer;
// flush walks the slots in order. A stamp wrap adds a min/max scan of the
// stamps and a renormalisation. The last result sits in the output register
// while the next request is accepted; a stalled receiver holds the result
// and stalls the sequencer when the next one is ready. Reset empties the
// slot table, pin set and free stack and loads the configuration defaults.
// Depends on lbsm_pkg, lbsm_ctrl, lbsm_dp and lbsm_div.
`timescale 1ns / 1ps

module lru_buffer_slot_manager_unit
#(
    parameter int SLOTS       = 8,
    parameter int PIN_ENTRIES = 64,
    parameter int FREE_DEPTH  = 64,
    parameter int STAMP_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [63:0] address,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [63:0] result_address,
    output logic [5:0]  slot,
    output logic [39:0] offset,
    output logic        writeback_valid,
    output logic [15:0] writeback_buffer,
    output logic        load_valid,
    output logic [15:0] load_buffer,
    output logic        created_new,
    output logic        last
);
    import lbsm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lbsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    lbsm_dp
    #(
        .SLOTS       (SLOTS),
        .PIN_ENTRIES (PIN_ENTRIES),
        .FREE_DEPTH  (FREE_DEPTH),
        .STAMP_BITS  (STAMP_BITS)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .address          (address),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .result_address   (result_address),
        .slot             (slot),
        .offset           (offset),
        .writeback_valid  (writeback_valid),
        .writeback_buffer (writeback_buffer),
        .load_valid       (load_valid),
        .load_buffer      (load_buffer),
        .created_new      (created_new),
        .last             (last)
    );

endmodule
